### rtl/plr_pkg.sv
// Shared types and codes for the positional array list.
package plr_pkg;

	// Command codes carried on the input side.
	typedef enum logic [2:0] {
		CMD_INSERT   = 3'd0,
		CMD_DELETE   = 3'd1,
		CMD_LOCATE   = 3'd2,
		CMD_RETRIEVE = 3'd3,
		CMD_CLEAR    = 3'd4
	} cmd_e;

	// Completion codes reported with every result.
	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_FULL  = 2'd1,
		STS_RANGE = 2'd2
	} status_e;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_UP,
		S_DOWN,
		S_DRAIN,
		S_PUT,
		S_SCAN,
		S_FETCH,
		S_DONE
	} state_e;

	localparam int POS_W = 7;
	localparam int VAL_W = 32;

	// One result as handed from the engine to the output register.
	typedef struct packed {
		logic              is_empty;
		logic [POS_W-1:0]  length;
		logic [POS_W-1:0]  found_position;
		logic [VAL_W-1:0]  read_value;
		status_e           status;
	} result_t;

endpackage

### rtl/plr_ram.sv
// Entry store: one write port and one registered read port.
module plr_ram #(
	parameter int DEPTH = 64,
	parameter int DATA_WIDTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  logic [DATA_WIDTH-1:0] wdata,
	input  logic                  re,
	input  logic [AW-1:0]         raddr,
	output logic [DATA_WIDTH-1:0] rdata
);

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds until the next read, so a finished lookup stays visible.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/plr_engine.sv
// Command sequencer: walks the entry store one entry per cycle for shifts and searches.
module plr_engine #(
	parameter int DEPTH = 64,
	parameter int DATA_WIDTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2:0]            in_cmd,
	input  logic [6:0]            in_pos,
	input  logic [31:0]           in_val,
	output logic                  res_valid,
	input  logic                  res_ready,
	output plr_pkg::result_t      res,
	output logic                  ram_we,
	output logic [AW-1:0]         ram_waddr,
	output logic [DATA_WIDTH-1:0] ram_wdata,
	output logic                  ram_re,
	output logic [AW-1:0]         ram_raddr,
	input  logic [DATA_WIDTH-1:0] ram_rdata
);

	import plr_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

	state_e                state_q, state_d;
	logic [2:0]            cmd_q;
	logic [CW-1:0]         posm1_q;
	logic [DATA_WIDTH-1:0] val_q;
	status_e               status_q;
	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         idx_q;
	logic [PW-1:0]         found_q;
	logic                  wen_s1;
	logic [AW-1:0]         waddr_s1;
	logic                  cmp_s1;

	logic [DATA_WIDTH-1:0] val_d;
	logic [31:0]           rd32;
	logic [PW-1:0]         pos_w, cnt_w, pm1_w, new_w;
	logic [CW-1:0]         idx_inc, idx_dec, new_cnt;
	logic                  accept, done, hit, scan_end, scan_issue;
	status_e               acc_status;
	state_e                acc_next;

	// Input values become DATA_WIDTH bits by sign extension or truncation.
	generate
		if (DATA_WIDTH > VAL_W) begin : g_wide
			assign val_d = {{(DATA_WIDTH - VAL_W){in_val[VAL_W-1]}}, in_val};
			assign rd32  = ram_rdata[VAL_W-1:0];
		end else if (DATA_WIDTH == VAL_W) begin : g_same
			assign val_d = in_val;
			assign rd32  = ram_rdata;
		end else begin : g_narrow
			assign val_d = in_val[DATA_WIDTH-1:0];
			assign rd32  = {{(VAL_W - DATA_WIDTH){ram_rdata[DATA_WIDTH-1]}}, ram_rdata};
		end
	endgenerate

	assign pos_w   = PW'(in_pos);
	assign cnt_w   = PW'(cnt_q);
	assign pm1_w   = pos_w - 1'b1;
	assign idx_inc = idx_q + 1'b1;
	assign idx_dec = idx_q - 1'b1;

	assign accept   = in_valid && in_ready;
	assign done     = res_valid && res_ready;
	assign hit      = cmp_s1 && (ram_rdata == val_q);
	assign scan_end = (idx_q == cnt_q);

	// Outcome of a new request, decided against the length before it.
	always_comb begin
		acc_status = STS_OK;
		acc_next   = S_DONE;
		unique case (in_cmd)
			CMD_INSERT: begin
				if (cnt_w == PW'(DEPTH)) begin
					acc_status = STS_FULL;
				end else if (in_pos == '0 || pos_w > cnt_w + 1'b1) begin
					acc_status = STS_RANGE;
				end else if (pos_w == cnt_w + 1'b1) begin
					acc_next = S_PUT;
				end else begin
					acc_next = S_UP;
				end
			end
			CMD_DELETE: begin
				if (in_pos == '0 || pos_w > cnt_w) begin
					acc_status = STS_RANGE;
				end else if (pos_w != cnt_w) begin
					acc_next = S_DOWN;
				end
			end
			CMD_LOCATE: begin
				acc_next = S_SCAN;
			end
			CMD_RETRIEVE: begin
				if (in_pos == '0 || pos_w > cnt_w) begin
					acc_status = STS_RANGE;
				end else begin
					acc_next = S_FETCH;
				end
			end
			default: begin
				acc_next = S_DONE;
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = acc_next;
				end
			end
			S_UP: begin
				if (idx_q == posm1_q) begin
					state_d = S_DRAIN;
				end
			end
			S_DOWN: begin
				if (idx_inc == cnt_q) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = (cmd_q == CMD_INSERT) ? S_PUT : S_DONE;
			end
			S_PUT: begin
				state_d = S_DONE;
			end
			S_SCAN: begin
				if (hit || scan_end) begin
					state_d = S_DONE;
				end
			end
			S_FETCH: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (done) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Store port controls. A shift reads one entry and writes it to the neighbouring address in the next cycle.
	always_comb begin
		in_ready   = 1'b0;
		res_valid  = 1'b0;
		ram_re     = 1'b0;
		ram_raddr  = idx_q[AW-1:0];
		scan_issue = 1'b0;
		unique case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_UP, S_DOWN: ram_re = 1'b1;
			S_SCAN: begin
				scan_issue = !hit && !scan_end;
				ram_re     = scan_issue;
			end
			S_FETCH: begin
				ram_re    = 1'b1;
				ram_raddr = posm1_q[AW-1:0];
			end
			S_DONE: res_valid = 1'b1;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign ram_we    = wen_s1 || (state_q == S_PUT);
	assign ram_waddr = wen_s1 ? waddr_s1 : posm1_q[AW-1:0];
	assign ram_wdata = wen_s1 ? ram_rdata : val_q;

	// Length after the request.
	always_comb begin
		new_cnt = cnt_q;
		if (status_q == STS_OK) begin
			unique case (cmd_q)
				CMD_INSERT: new_cnt = cnt_q + 1'b1;
				CMD_DELETE: new_cnt = cnt_q - 1'b1;
				CMD_CLEAR:  new_cnt = '0;
				default:    new_cnt = cnt_q;
			endcase
		end
	end

	assign new_w = PW'(new_cnt);

	assign res.status         = status_q;
	assign res.read_value     = (cmd_q == CMD_RETRIEVE && status_q == STS_OK) ? rd32 : '0;
	assign res.found_position = (cmd_q == CMD_LOCATE) ? found_q[POS_W-1:0] : '0;
	assign res.length         = new_w[POS_W-1:0];
	assign res.is_empty       = (new_cnt == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			wen_s1  <= 1'b0;
			cmp_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			wen_s1  <= (state_q == S_UP) || (state_q == S_DOWN);
			cmp_s1  <= scan_issue;
			if (done) begin
				cnt_q <= new_cnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= in_cmd;
			posm1_q  <= pm1_w[CW-1:0];
			val_q    <= val_d;
			status_q <= acc_status;
			unique case (in_cmd)
				CMD_INSERT: idx_q <= cnt_q - 1'b1;
				CMD_DELETE: idx_q <= pos_w[CW-1:0];
				default:    idx_q <= '0;
			endcase
		end else begin
			unique case (state_q)
				S_UP: begin
					idx_q    <= idx_dec;
					waddr_s1 <= idx_inc[AW-1:0];
				end
				S_DOWN: begin
					idx_q    <= idx_inc;
					waddr_s1 <= idx_dec[AW-1:0];
				end
				S_SCAN: begin
					// The index has already moved past the entry under compare,
					// so it equals that entry's 1-based position.
					if (hit) begin
						found_q <= PW'(idx_q);
					end else if (scan_end) begin
						found_q <= cnt_w + 1'b1;
					end else begin
						idx_q <= idx_inc;
					end
				end
				default: begin
					idx_q <= idx_q;
				end
			endcase
		end
	end

endmodule

### rtl/positional_array_list_top.sv
// Top level of the positional array list: stream ports, engine, store and result register.
//
//  Channel  Direction  Handshake          Payload
//  s_       in         s_tvalid/s_tready  tuser: cmd; tdata: position, value
//  m_       out        m_tvalid/m_tready  tdata: status, read_value, found_position, length, is_empty
//
// Insert and delete shift the entries between the position and the end of the list, locate scans
// from the first entry until a match or the end, and retrieve reads one entry; appending,
// deleting the last entry, clear, unknown commands and rejected requests need no walk. The
// walk moves one entry per cycle through the store's single write port and registered read port.
// Reset clears the length and the control state; entries need no clearing pass.
// A new request is taken while a finished result waits in the output register; the
// engine then holds its own result until that register frees.
module positional_array_list_top #(
	parameter int DEPTH = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // [6:0] position, [38:7] value, [39] zero
	input  logic [2:0]  s_tuser,  // [2:0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata   // [1:0] status, [33:2] read_value, [40:34] found_position,
	                              // [47:41] length, [48] is_empty, [55:49] zero
);

	import plr_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic                  res_valid, res_ready;
	result_t               res;
	result_t               out_q;
	logic                  out_valid_q;
	logic                  ram_we, ram_re;
	logic [AW-1:0]         ram_waddr, ram_raddr;
	logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

	plr_engine #(
		.DEPTH(DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_cmd(s_tuser),
		.in_pos(s_tdata[6:0]),
		.in_val(s_tdata[38:7]),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.ram_we(ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re(ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

	plr_ram #(
		.DEPTH(DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_q.is_empty, out_q.length, out_q.found_position,
		out_q.read_value, out_q.status};

endmodule
